[design/icr_pkg.sv]
`timescale 1ns / 1ps

package icr_pkg;

  // Number of interrupt sources in use (1 to 32)
  localparam int unsigned NumSources = 32;
  localparam int unsigned SrcW       = 32;
  localparam int unsigned TopW       = 5;
  localparam int unsigned AddrW      = 12;
  localparam int unsigned FuncW      = 2;
  localparam int unsigned CfgIdxW    = 2;

  // Bits of sources that exist
  localparam logic [SrcW-1:0] SrcMask = SrcW'((64'(1) << NumSources) - 64'(1));

  // Access kinds
  localparam logic [FuncW-1:0] FuncNone  = 2'd0;
  localparam logic [FuncW-1:0] FuncWrite = 2'd1;
  localparam logic [FuncW-1:0] FuncRead  = 2'd2;

  // Register offsets
  localparam logic [AddrW-1:0] AddrDisable = 12'h300;
  localparam logic [AddrW-1:0] AddrEnable  = 12'h380;
  localparam logic [AddrW-1:0] AddrMask    = 12'h400;
  localparam logic [AddrW-1:0] AddrStatus  = 12'h480;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgActiveHigh = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEdge       = 2'd1;

  typedef struct packed {
    logic [SrcW-1:0] active_high;
    logic [SrcW-1:0] edge_sel;
  } icr_cfg_t;

  typedef struct packed {
    logic [SrcW-1:0] enable;
    logic [SrcW-1:0] latched;
    logic [SrcW-1:0] prev_levels;
  } icr_state_t;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [AddrW-1:0] reg_addr;
    logic [SrcW-1:0]  write_data;
    logic [SrcW-1:0]  line_levels;
  } icr_item_t;

  typedef struct packed {
    logic             addr_error;
    logic [TopW-1:0]  top_source;
    logic             irq_request;
    logic [SrcW-1:0]  read_data;
  } icr_result_t;

endpackage

[design/interrupt_controller_regs.sv]
`timescale 1ns / 1ps

// Register block of a 32-source interrupt controller. Every input beat
// samples the raw interrupt lines and may carry one register read or write
// (0x300 enable-clear, 0x380 enable-set, 0x400 enable mask, 0x480 pending
// status, where writing ones acknowledges edge-latched bits); each beat
// yields exactly one result beat with read data, the request output, the
// highest pending enabled source and an address-error flag. The block takes
// one beat per cycle while the output is not stalled: a beat waits in the
// input register and is evaluated on its way into the output register,
// from which its result is offered. A stalled output holds both registers
// and drops input ready once both are full. Polarity and trigger mode are
// set through the configuration port, which is always ready and should only
// be written while no beat is in flight.
module interrupt_controller_regs import icr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input beat: func[1:0], reg_addr[13:2], write_data[45:14],
  // line_levels[77:46], zero padding[79:78]
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [79:0]        s_axis_tdata,
  // Result beat: read_data[31:0], irq_request[32], top_source[37:33],
  // addr_error[38], zero padding[39]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [39:0]        m_axis_tdata,
  // Configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SrcW-1:0]    cfg_data_i
);

  icr_cfg_t    cfg_q;
  icr_state_t  state_q, state_d;
  icr_item_t   item_q;
  logic        in_valid_q;
  icr_result_t result_q, result_d;
  logic        out_valid_q;
  logic        out_free;
  logic        s1_adv;
  logic        s_acc;

  // Handshake between the two stages
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_adv        = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_high <= '1;
      cfg_q.edge_sel    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgActiveHigh: cfg_q.active_high <= cfg_data_i;
        CfgEdge:       cfg_q.edge_sel    <= cfg_data_i;
        default:       cfg_q             <= cfg_q;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      item_q.func        <= s_axis_tdata[1:0];
      item_q.reg_addr    <= s_axis_tdata[13:2];
      item_q.write_data  <= s_axis_tdata[45:14];
      item_q.line_levels <= s_axis_tdata[77:46];
    end
  end

  icr_eval u_eval (
    .item_i   (item_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Commit state as the beat leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, result_q};

`ifndef SYNTH
  a_unused_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.enable & ~SrcMask) == '0) else $error("enable bit set on unused source");

  a_unused_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.latched & ~SrcMask) == '0) else $error("latch set on unused source");

  a_top_implies_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (result_q.top_source != '0) |-> result_q.irq_request)
    else $error("top_source without request");

  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && result_q.addr_error |-> (result_q.read_data == '0))
    else $error("read data on address error");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q && $stable(state_q))
    else $error("input stage dropped a stalled beat");
`endif

endmodule

[design/icr_eval.sv]
`timescale 1ns / 1ps

module icr_eval import icr_pkg::*; (
  input  icr_item_t   item_i,
  input  icr_state_t  state_i,
  input  icr_cfg_t    cfg_i,
  output icr_state_t  state_o,
  output icr_result_t result_o
);

  logic [SrcW-1:0] prev_asserted;
  logic [SrcW-1:0] now_asserted;
  logic [SrcW-1:0] new_edges;
  logic [SrcW-1:0] latched_mid;
  logic [SrcW-1:0] ack;
  logic [SrcW-1:0] enable_nx;
  logic [SrcW-1:0] latched_nx;
  logic [SrcW-1:0] req;
  logic [SrcW-1:0] rdata;
  logic            known;
  logic            is_wr;
  logic            is_rd;
  logic [TopW-1:0] top;

  // Sample lines and latch new edges, judged with the current polarity
  assign prev_asserted = ~(state_i.prev_levels ^ cfg_i.active_high);
  assign now_asserted  = ~(item_i.line_levels ^ cfg_i.active_high);
  assign new_edges     = now_asserted & ~prev_asserted & cfg_i.edge_sel & SrcMask;
  assign latched_mid   = state_i.latched | new_edges;

  assign known = item_i.reg_addr inside {AddrDisable, AddrEnable, AddrMask, AddrStatus};
  assign is_wr = (item_i.func == FuncWrite);
  assign is_rd = (item_i.func == FuncRead);

  // Perform the register access
  always_comb begin
    enable_nx = state_i.enable;
    ack       = '0;
    rdata     = '0;
    if (is_wr && known) begin
      case (item_i.reg_addr)
        AddrDisable: enable_nx = state_i.enable & ~item_i.write_data;
        AddrEnable:  enable_nx = state_i.enable | item_i.write_data;
        AddrStatus:  ack = item_i.write_data;
        default:     enable_nx = state_i.enable;
      endcase
    end else if (is_rd && known) begin
      case (item_i.reg_addr)
        AddrMask:   rdata = state_i.enable & SrcMask;
        AddrStatus: rdata = ((now_asserted & ~cfg_i.edge_sel) |
                             (latched_mid & cfg_i.edge_sel)) & SrcMask;
        default:    rdata = '0;
      endcase
    end
  end

  // A new edge wins over an acknowledge in the same beat
  assign latched_nx = ((latched_mid & ~ack) | new_edges) & SrcMask;

  assign req = ((now_asserted & ~cfg_i.edge_sel) | (latched_nx & cfg_i.edge_sel)) &
               enable_nx & SrcMask;

  // Pick the highest numbered request
  always_comb begin
    top = '0;
    for (int i = 0; i < SrcW; i++) begin
      if (req[i]) top = TopW'(i);
    end
  end

  assign state_o.enable      = enable_nx & SrcMask;
  assign state_o.latched     = latched_nx;
  assign state_o.prev_levels = item_i.line_levels;

  assign result_o.read_data   = rdata;
  assign result_o.irq_request = |req;
  assign result_o.top_source  = top;
  assign result_o.addr_error  = (is_wr || is_rd) && !known;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import icr_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseBeats = 125;
  localparam int unsigned NumPhases  = 8;

  // Access kind the block treats as no access
  localparam logic [FuncW-1:0] FuncSpare = 2'd3;

  // Offsets that hit no register
  localparam logic [AddrW-1:0] AddrNoReg      = 12'hABC;
  localparam logic [AddrW-1:0] AddrTopEnd     = 12'hFFF;
  localparam logic [AddrW-1:0] AddrNearStatus = 12'h484;

  localparam icr_result_t Untyped = '0;

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [79:0]        s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [39:0]        m_axis_tdata;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i   = CfgActiveHigh;
  logic [SrcW-1:0]    cfg_data_i    = '0;

  interrupt_controller_regs DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  typedef struct {
    logic               is_cfg;
    logic [CfgIdxW-1:0] cfg_idx;
    logic [SrcW-1:0]    cfg_val;
    icr_item_t          beat;
    logic               typed;
    icr_result_t        want;
  } dir_row_t;

  // Shadow of the controller and the results still owed by it
  icr_cfg_t    ctl_cfg;
  icr_state_t  ctl_state;
  icr_result_t awaited_results[$];
  dir_row_t    dir_rows[$];

  int unsigned     bad_results  = 0;
  int unsigned     result_count = 0;
  int unsigned     cycle_count  = 0;
  int unsigned     tx_idle_pct  = 0;
  int unsigned     rx_stall_pct = 0;
  int unsigned     hold_ticket  = 0;
  logic [SrcW-1:0] gen_levels   = '0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic icr_result_t res(input logic [SrcW-1:0] rd, input logic irq,
                                      input logic [TopW-1:0] top, input logic err);
    icr_result_t r;
    r.read_data   = rd;
    r.irq_request = irq;
    r.top_source  = top;
    r.addr_error  = err;
    return r;
  endfunction

  // Level sources that are asserted plus edge sources that have latched
  function automatic logic [SrcW-1:0] pending_of(input logic [SrcW-1:0] levels);
    logic [SrcW-1:0] hot;
    hot = ~(levels ^ ctl_cfg.active_high);
    return ((hot & ~ctl_cfg.edge_sel) | (ctl_state.latched & ctl_cfg.edge_sel)) & SrcMask;
  endfunction

  // Advance the shadow state by one beat and form its result
  function automatic icr_result_t predict_irq_result(input icr_item_t beat);
    logic [SrcW-1:0] was_on;
    logic [SrcW-1:0] now_on;
    logic [SrcW-1:0] rising;
    logic [SrcW-1:0] ack;
    logic [SrcW-1:0] req;
    logic            known;
    icr_result_t     r;
    was_on = ~(ctl_state.prev_levels ^ ctl_cfg.active_high);
    now_on = ~(beat.line_levels ^ ctl_cfg.active_high);
    rising = now_on & ~was_on & ctl_cfg.edge_sel & SrcMask;
    ack    = '0;
    r      = '0;
    known  = (beat.reg_addr == AddrDisable) || (beat.reg_addr == AddrEnable) ||
             (beat.reg_addr == AddrMask) || (beat.reg_addr == AddrStatus);
    ctl_state.latched     |= rising;
    ctl_state.prev_levels = beat.line_levels;
    if (beat.func == FuncWrite || beat.func == FuncRead) begin
      if (!known) begin
        r.addr_error = 1'b1;
      end else if (beat.func == FuncWrite) begin
        case (beat.reg_addr)
          AddrDisable: ctl_state.enable &= ~beat.write_data;
          AddrEnable:  ctl_state.enable = (ctl_state.enable | beat.write_data) & SrcMask;
          AddrStatus:  ack = beat.write_data;
          default: ;
        endcase
      end else if (beat.reg_addr == AddrMask) begin
        r.read_data = ctl_state.enable & SrcMask;
      end else if (beat.reg_addr == AddrStatus) begin
        r.read_data = pending_of(beat.line_levels);
      end
    end
    // A new edge wins over an acknowledge in the same beat
    ctl_state.latched = ((ctl_state.latched & ~ack) | rising) & SrcMask;
    ctl_state.enable &= SrcMask;
    req = pending_of(beat.line_levels) & ctl_state.enable;
    r.irq_request = |req;
    for (int i = 0; i < SrcW; i++) begin
      if (req[i]) r.top_source = TopW'(i);
    end
    return r;
  endfunction

  // Mostly legal accesses; lines sometimes move one bit at a time and sometimes jump, so edges keep coming
  function automatic icr_item_t rand_beat();
    icr_item_t   b;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 42) b.func = FuncWrite;
    else if (pick < 82) b.func = FuncRead;
    else if (pick < 92) b.func = FuncNone;
    else b.func = FuncSpare;
    if ($urandom_range(0, 99) < 88) begin
      case ($urandom_range(0, 3))
        0: b.reg_addr = AddrDisable;
        1: b.reg_addr = AddrEnable;
        2: b.reg_addr = AddrMask;
        default: b.reg_addr = AddrStatus;
      endcase
    end else begin
      b.reg_addr = AddrW'($urandom_range(0, 4095));
    end
    case ($urandom_range(0, 4))
      0: b.write_data = $urandom;
      1: b.write_data = SrcW'(1) << $urandom_range(0, SrcW - 1);
      2: b.write_data = $urandom & $urandom;
      3: b.write_data = '1;
      default: b.write_data = '0;
    endcase
    case ($urandom_range(0, 5))
      0: b.line_levels = gen_levels ^ (SrcW'(1) << $urandom_range(0, SrcW - 1));
      1: b.line_levels = gen_levels;
      2: b.line_levels = $urandom & $urandom & $urandom;
      3: b.line_levels = $urandom;
      4: b.line_levels = ~gen_levels;
      default: b.line_levels = gen_levels ^ ($urandom & $urandom & $urandom);
    endcase
    gen_levels = b.line_levels;
    return b;
  endfunction

  task automatic add_row(input logic [FuncW-1:0] f, input logic [AddrW-1:0] a,
                         input logic [SrcW-1:0] wd, input logic [SrcW-1:0] lv,
                         input logic typed, input icr_result_t want);
    dir_row_t row;
    row.is_cfg            = 1'b0;
    row.cfg_idx           = CfgActiveHigh;
    row.cfg_val           = '0;
    row.beat.func         = f;
    row.beat.reg_addr     = a;
    row.beat.write_data   = wd;
    row.beat.line_levels  = lv;
    row.typed             = typed;
    row.want              = want;
    dir_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic [CfgIdxW-1:0] idx, input logic [SrcW-1:0] val);
    dir_row_t row;
    row         = '{default: '0};
    row.is_cfg  = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    dir_rows.push_back(row);
  endtask

  task automatic log_bad(input string msg);
    bad_results++;
    if (bad_results <= 10) $display("%s", msg);
  endtask

  // Drop valid and hold until every owed result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    cfg_valid_i   <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [SrcW-1:0] val);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CfgActiveHigh) ctl_cfg.active_high = val;
    else if (idx == CfgEdge) ctl_cfg.edge_sel = val;
  endtask

  // Offer one beat after a random gap; valid stays up for the next caller
  task automatic send_beat(input icr_item_t beat, input logic typed,
                           input icr_result_t want);
    icr_result_t predicted;
    cfg_valid_i <= 1'b0;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < tx_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, beat.line_levels, beat.write_data, beat.reg_addr, beat.func};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = predict_irq_result(beat);
    awaited_results.push_back(typed ? want : predicted);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : check_results
    icr_result_t got;
    icr_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.read_data   = m_axis_tdata[31:0];
      got.irq_request = m_axis_tdata[32];
      got.top_source  = m_axis_tdata[37:33];
      got.addr_error  = m_axis_tdata[38];
      if (awaited_results.size() == 0) begin
        log_bad($sformatf("result %0d arrived with no beat owing it: rdata=%h irq=%0d top=%0d err=%0d",
                          result_count, got.read_data, got.irq_request, got.top_source,
                          got.addr_error));
      end else begin
        want = awaited_results.pop_front();
        if (got.read_data !== want.read_data || got.irq_request !== want.irq_request ||
            got.top_source !== want.top_source || got.addr_error !== want.addr_error) begin
          log_bad($sformatf({"result %0d mismatch: expected rdata=%h irq=%0d top=%0d err=%0d,",
                             " got rdata=%h irq=%0d top=%0d err=%0d"},
                            result_count, want.read_data, want.irq_request, want.top_source,
                            want.addr_error, got.read_data, got.irq_request, got.top_source,
                            got.addr_error));
        end
      end
      result_count++;
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** interrupt_controller_regs: FAILED **");
    $finish;
  end

  initial begin
    logic [SrcW-1:0] pol;
    logic [SrcW-1:0] edg;
    ctl_cfg.active_high = '1;
    ctl_cfg.edge_sel    = '0;
    ctl_state           = '0;

    // Level mode, active high: reset values, bad offsets, enable and read back
    add_row(FuncNone,  AddrMask,    '0,           '0,           1'b1,
            res('0, 1'b0, 5'd0, 1'b0));
    add_row(FuncRead,  AddrMask,    '0,           '0,           1'b1,
            res('0, 1'b0, 5'd0, 1'b0));
    add_row(FuncWrite, AddrNoReg,   '1,           '0,           1'b1,
            res('0, 1'b0, 5'd0, 1'b1));
    add_row(FuncRead,  AddrTopEnd,  '0,           '0,           1'b1,
            res('0, 1'b0, 5'd0, 1'b1));
    add_row(FuncSpare, AddrEnable,  '1,           '0,           1'b0, Untyped);
    add_row(FuncRead,  AddrEnable,  '0,           '0,           1'b0, Untyped);
    add_row(FuncWrite, AddrEnable,  '1,           '0,           1'b1,
            res('0, 1'b0, 5'd0, 1'b0));
    add_row(FuncRead,  AddrMask,    '0,           '0,           1'b1,
            res('1, 1'b0, 5'd0, 1'b0));
    add_row(FuncNone,  AddrMask,    '0,           '1,           1'b1,
            res('0, 1'b1, 5'd31, 1'b0));
    add_row(FuncNone,  AddrMask,    '0,           32'h1,        1'b1,
            res('0, 1'b1, 5'd0, 1'b0));
    add_row(FuncRead,  AddrStatus,  '0,           32'h80000001, 1'b1,
            res(32'h80000001, 1'b1, 5'd31, 1'b0));
    add_row(FuncWrite, AddrMask,    '0,           32'h80000001, 1'b0, Untyped);
    add_row(FuncWrite, AddrDisable, 32'h80000000, 32'h80000001, 1'b0, Untyped);
    add_row(FuncRead,  AddrDisable, '0,           32'h80000001, 1'b0, Untyped);
    add_row(FuncWrite, AddrDisable, '1,           '1,           1'b1,
            res('0, 1'b0, 5'd0, 1'b0));
    // Edge mode: latch, acknowledge, edge racing its acknowledge
    add_cfg(CfgEdge, '1);
    add_row(FuncWrite, AddrEnable,  '1,           '0,           1'b0, Untyped);
    add_row(FuncNone,  AddrMask,    '0,           '1,           1'b0, Untyped);
    add_row(FuncRead,  AddrStatus,  '0,           '0,           1'b0, Untyped);
    add_row(FuncWrite, AddrStatus,  '1,           '0,           1'b0, Untyped);
    add_row(FuncWrite, AddrStatus,  32'h4,        32'h4,        1'b0, Untyped);
    // Falling edges, then latches hidden in level mode and shown again
    add_cfg(CfgActiveHigh, '0);
    add_row(FuncNone,  AddrMask,    '0,           '0,           1'b0, Untyped);
    add_cfg(CfgEdge, '0);
    add_row(FuncRead,  AddrStatus,  '0,           '1,           1'b0, Untyped);
    add_cfg(CfgEdge, '1);
    add_row(FuncRead,  AddrStatus,  '0,           '1,           1'b0, Untyped);
    add_row(FuncWrite, AddrNearStatus, '1,        '1,           1'b0, Untyped);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_cfg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
      else send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    end
    gen_levels = ctl_state.prev_levels;

    // Random phases over polarity/trigger settings and idle patterns
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin pol = '1; edg = '0; end
        1: begin pol = '0; edg = '1; end
        2: begin pol = '1; edg = '1; end
        3: begin pol = '0; edg = '0; end
        default: begin pol = $urandom; edg = $urandom; end
      endcase
      write_cfg(CfgActiveHigh, pol);
      write_cfg(CfgEdge, edg);
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 59; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 59; end
        default: begin tx_idle_pct = 23; rx_stall_pct = 23; end
      endcase
      for (int n = 0; n < PhaseBeats; n++) begin
        if (n == 40) hold_ticket <= hold_ticket + 1;
        if (n == 90) drain_results();
        send_beat(rand_beat(), 1'b0, Untyped);
      end
    end

    // Let the pipeline empty and watch for stray beats
    drain_results();
    repeat (4) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      log_bad($sformatf("%0d results never arrived", awaited_results.size()));
    end
    if (bad_results == 0) begin
      $display("** interrupt_controller_regs: PASSED **");
    end else begin
      $display("** interrupt_controller_regs: FAILED **");
    end
    $finish;
  end

endmodule

[interrupt_controller_regs.f]
design/icr_pkg.sv
design/icr_eval.sv
design/interrupt_controller_regs.sv
test/tb_top.sv
